### rtl/ssb_pkg.sv
`default_nettype none

package ssb_pkg;

   // Default limits for the top-level parameters.
   localparam int MAX_SPRITE_DIM_DEF = 256;
   localparam int MAX_SCREEN_DIM_DEF = 1024;

   // Field and register widths.
   localparam int DIM_W      = 9;
   localparam int SCALE_W    = 9;
   localparam int POS_W      = 11;
   localparam int SCR_W      = 11;
   localparam int KEY_W      = 8;
   localparam int PIX_W      = 8;
   localparam int ADDR_W     = 16;
   localparam int COORD_W    = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   // A scale of 256 or more draws the sprite unscaled.
   localparam logic [SCALE_W-1:0] FULL_SCALE  = 9'd256;
   localparam int                 SCALE_SHIFT = 8;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_SRC_WIDTH     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_HEIGHT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE         = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_POS_X         = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_POS_Y         = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_KEY           = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd7;

   // Register reset values.
   localparam logic [DIM_W-1:0]   RST_SRC_WIDTH     = 9'd16;
   localparam logic [DIM_W-1:0]   RST_SRC_HEIGHT    = 9'd16;
   localparam logic [SCALE_W-1:0] RST_SCALE         = 9'd256;
   localparam logic [POS_W-1:0]   RST_POS_X         = 11'd0;
   localparam logic [POS_W-1:0]   RST_POS_Y         = 11'd0;
   localparam logic [KEY_W-1:0]   RST_KEY           = 8'd0;
   localparam logic [SCR_W-1:0]   RST_SCREEN_WIDTH  = 11'd640;
   localparam logic [SCR_W-1:0]   RST_SCREEN_HEIGHT = 11'd480;

   // Request commands.
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_STEP = 1'b1;

endpackage

`default_nettype wire

### rtl/sprite_scale_blit.sv
`default_nettype none

// Scaled, color-keyed sprite blitter. Sprite pixels are loaded with load
// requests into a 64K x 8 synchronous store; each step request then yields
// one destination pixel, columns outer and rows inner, clipped to the screen
// at the configured position and shrunk by nearest-neighbor sampling when the
// scale is below 256. A step inside a draw passes through acceptance, the
// store read, and the load of the result register, which lets the next
// request in while the result waits. The first step of a draw also runs four
// divisions through one shared restoring divider, one quotient bit per cycle;
// after that the sample positions advance by adding precomputed quotient and
// remainder steps. A step whose clipped area is empty returns a single result
// with nothing_to_draw and last set.
module sprite_scale_blit #(
   parameter int MAX_SPRITE_DIM = ssb_pkg::MAX_SPRITE_DIM_DEF,
   parameter int MAX_SCREEN_DIM = ssb_pkg::MAX_SCREEN_DIM_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write,
   input  wire logic [ssb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [ssb_pkg::CSR_DATA_W-1:0]   csr_data,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic                             req_cmd,
   input  wire logic [ssb_pkg::ADDR_W-1:0]       req_load_index,
   input  wire logic [ssb_pkg::PIX_W-1:0]        req_load_pixel,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic                                  rsp_write_enable,
   output logic [ssb_pkg::COORD_W-1:0]           rsp_screen_x,
   output logic [ssb_pkg::COORD_W-1:0]           rsp_screen_y,
   output logic [ssb_pkg::PIX_W-1:0]             rsp_pixel,
   output logic                                  rsp_last,
   output logic                                  rsp_nothing_to_draw
);

   localparam int SD_W  = $clog2(MAX_SPRITE_DIM + 1);
   localparam int SC_W  = $clog2(MAX_SCREEN_DIM + 1);
   localparam int MX_W  = (SC_W > SD_W) ? ((SC_W > ssb_pkg::POS_W) ? SC_W : ssb_pkg::POS_W)
                                        : ((SD_W > ssb_pkg::POS_W) ? SD_W : ssb_pkg::POS_W);
   localparam int WK_W  = MX_W + 3;
   localparam int DN_W  = 2 * SD_W;
   localparam int DC_W  = $clog2(DN_W);
   localparam int MP_W  = SD_W + ssb_pkg::SCALE_W;
   localparam int AD_W  = ((DN_W > ssb_pkg::ADDR_W) ? DN_W : ssb_pkg::ADDR_W) + 1;
   localparam int MEM_DEPTH = 2 ** ssb_pkg::ADDR_W;

   localparam logic [DC_W-1:0] DIV_LAST = DC_W'(DN_W - 1);

   // Divider jobs run at the start of a draw, in this order.
   localparam logic [1:0] OP_COL_STEP  = 2'd0;
   localparam logic [1:0] OP_COL_START = 2'd1;
   localparam logic [1:0] OP_ROW_STEP  = 2'd2;
   localparam logic [1:0] OP_ROW_START = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_DIV,
      S_READ,
      S_OUT
   } state_type;

   // Configuration registers.
   logic [ssb_pkg::DIM_W-1:0]   cfg_src_width_ff;
   logic [ssb_pkg::DIM_W-1:0]   cfg_src_height_ff;
   logic [ssb_pkg::SCALE_W-1:0] cfg_scale_ff;
   logic [ssb_pkg::POS_W-1:0]   cfg_pos_x_ff;
   logic [ssb_pkg::POS_W-1:0]   cfg_pos_y_ff;
   logic [ssb_pkg::KEY_W-1:0]   cfg_key_ff;
   logic [ssb_pkg::SCR_W-1:0]   cfg_screen_width_ff;
   logic [ssb_pkg::SCR_W-1:0]   cfg_screen_height_ff;

   // Window arithmetic.
   logic signed [WK_W-1:0] sw_w, sh_w, dw_w, dh_w, px_w, py_w, scrw_w, scrh_w;
   logic signed [WK_W-1:0] x0_w, y0_w, x1_w, y1_w;
   logic [SD_W-1:0]        sw_c, sh_c, dw_c, dh_c;
   logic [MP_W-1:0]        prod_w_c, prod_h_c;
   logic                   vis_in;

   logic [SD_W-1:0] win_sw_ff, win_sh_ff, win_dw_ff, win_dh_ff;
   logic [SD_W-1:0] win_x0_ff, win_y0_ff, win_x1_ff, win_y1_ff;
   logic            win_vis_ff;

   // Control.
   state_type state_ff;
   logic      in_run_ff;
   logic      empty_ff;

   // Walk counters and sample positions.
   logic [SD_W-1:0] col_ff, row_ff;
   logic [SD_W-1:0] scol_ff, scol_rem_ff, srow_ff, srow_rem_ff;
   logic [SD_W-1:0] srow0_ff, srow0_rem_ff;
   logic [SD_W-1:0] kqx_ff, krx_ff, kqy_ff, kry_ff;

   // Divider.
   logic [1:0]      div_op_ff;
   logic [DC_W-1:0] div_cnt_ff;
   logic [SD_W-1:0] div_rem_ff;
   logic [DN_W-1:0] div_quo_ff;
   logic [SD_W-1:0] div_den_ff;
   logic [SD_W:0]   div_shift;
   logic            div_ge;
   logic [SD_W:0]   div_rem_in;
   logic [DN_W-1:0] div_quo_in;
   logic [1:0]      ld_op;
   logic [SD_W-1:0] ld_factor, ld_size;
   logic [DN_W-1:0] ld_num_in;
   logic [SD_W-1:0] ld_den_in;

   // Walk step.
   logic                      do_walk;
   logic [SD_W:0]             row_nx, col_nx;
   logic                      row_wrap, col_done;
   logic [SD_W:0]             sr_sum, sc_sum;
   logic                      sr_ge, sc_ge;
   logic [SD_W-1:0]           srow_rem_in, scol_rem_in, srow_in, scol_in;
   logic [ssb_pkg::ADDR_W-1:0] rd_addr;

   // Result staging.
   logic [ssb_pkg::COORD_W-1:0] out_x_ff, out_y_ff;
   logic                        out_last_ff;
   logic [ssb_pkg::PIX_W-1:0]   rdata_ff;
   logic [ssb_pkg::PIX_W-1:0]   store_mem [0:MEM_DEPTH-1];

   logic                        rsp_valid_ff;
   logic                        rsp_we_ff;
   logic [ssb_pkg::COORD_W-1:0] rsp_x_ff, rsp_y_ff;
   logic [ssb_pkg::PIX_W-1:0]   rsp_pixel_ff;
   logic                        rsp_last_ff;
   logic                        rsp_none_ff;

   logic req_accept;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_write_enable    = rsp_we_ff;
   assign rsp_screen_x        = rsp_x_ff;
   assign rsp_screen_y        = rsp_y_ff;
   assign rsp_pixel           = rsp_pixel_ff;
   assign rsp_last            = rsp_last_ff;
   assign rsp_nothing_to_draw = rsp_none_ff;

   // Clipped window in sprite destination space, [x0,x1) by [y0,y1).
   always_comb begin
      sw_w = $signed({{(WK_W-ssb_pkg::DIM_W){1'b0}}, cfg_src_width_ff});
      if (sw_w > WK_W'(MAX_SPRITE_DIM)) begin
         sw_w = WK_W'(MAX_SPRITE_DIM);
      end
      sh_w = $signed({{(WK_W-ssb_pkg::DIM_W){1'b0}}, cfg_src_height_ff});
      if (sh_w > WK_W'(MAX_SPRITE_DIM)) begin
         sh_w = WK_W'(MAX_SPRITE_DIM);
      end
      scrw_w = $signed({{(WK_W-ssb_pkg::SCR_W){1'b0}}, cfg_screen_width_ff});
      if (scrw_w > WK_W'(MAX_SCREEN_DIM)) begin
         scrw_w = WK_W'(MAX_SCREEN_DIM);
      end
      scrh_w = $signed({{(WK_W-ssb_pkg::SCR_W){1'b0}}, cfg_screen_height_ff});
      if (scrh_w > WK_W'(MAX_SCREEN_DIM)) begin
         scrh_w = WK_W'(MAX_SCREEN_DIM);
      end
      sw_c = sw_w[SD_W-1:0];
      sh_c = sh_w[SD_W-1:0];
      prod_w_c = MP_W'(sw_c) * MP_W'(cfg_scale_ff);
      prod_h_c = MP_W'(sh_c) * MP_W'(cfg_scale_ff);
      if (cfg_scale_ff < ssb_pkg::FULL_SCALE) begin
         dw_c = SD_W'(prod_w_c >> ssb_pkg::SCALE_SHIFT);
         dh_c = SD_W'(prod_h_c >> ssb_pkg::SCALE_SHIFT);
      end else begin
         dw_c = sw_c;
         dh_c = sh_c;
      end
      dw_w = $signed({{(WK_W-SD_W){1'b0}}, dw_c});
      dh_w = $signed({{(WK_W-SD_W){1'b0}}, dh_c});
      px_w = $signed({{(WK_W-ssb_pkg::POS_W){cfg_pos_x_ff[ssb_pkg::POS_W-1]}}, cfg_pos_x_ff});
      py_w = $signed({{(WK_W-ssb_pkg::POS_W){cfg_pos_y_ff[ssb_pkg::POS_W-1]}}, cfg_pos_y_ff});
      x0_w = (px_w < 0) ? -px_w : '0;
      y0_w = (py_w < 0) ? -py_w : '0;
      x1_w = dw_w;
      if (px_w + dw_w > scrw_w) begin
         x1_w = scrw_w - px_w;
      end
      y1_w = dh_w;
      if (py_w + dh_w > scrh_w) begin
         y1_w = scrh_w - py_w;
      end
      vis_in = (x0_w < x1_w) && (y0_w < y1_w);
   end

   // Divider operand selection: a step job divides the source size, a start
   // job divides the first clipped position times the source size.
   always_comb begin
      ld_op = (state_ff == S_CHECK) ? OP_COL_STEP : (div_op_ff + 2'd1);
      unique case (ld_op)
         OP_COL_STEP: begin
            ld_factor = SD_W'(1);
            ld_size   = win_sw_ff;
            ld_den_in = win_dw_ff;
         end
         OP_COL_START: begin
            ld_factor = win_x0_ff;
            ld_size   = win_sw_ff;
            ld_den_in = win_dw_ff;
         end
         OP_ROW_STEP: begin
            ld_factor = SD_W'(1);
            ld_size   = win_sh_ff;
            ld_den_in = win_dh_ff;
         end
         OP_ROW_START: begin
            ld_factor = win_y0_ff;
            ld_size   = win_sh_ff;
            ld_den_in = win_dh_ff;
         end
      endcase
      ld_num_in = DN_W'(ld_factor) * DN_W'(ld_size);
   end

   // One quotient bit per cycle.
   always_comb begin
      div_shift  = {div_rem_ff, div_quo_ff[DN_W-1]};
      div_ge     = div_shift >= {1'b0, div_den_ff};
      div_rem_in = div_ge ? (div_shift - {1'b0, div_den_ff}) : div_shift;
      div_quo_in = {div_quo_ff[DN_W-2:0], div_ge};
   end

   // Advance to the next destination pixel; sample positions move by the
   // precomputed quotient and remainder of size over scaled size.
   always_comb begin
      do_walk  = ((state_ff == S_CHECK) && win_vis_ff && in_run_ff) || (state_ff == S_READ);
      row_nx   = {1'b0, row_ff} + 1'b1;
      col_nx   = {1'b0, col_ff} + 1'b1;
      row_wrap = row_nx >= {1'b0, win_y1_ff};
      col_done = col_nx >= {1'b0, win_x1_ff};

      sr_sum      = {1'b0, srow_rem_ff} + {1'b0, kry_ff};
      sr_ge       = sr_sum >= {1'b0, win_dh_ff};
      srow_rem_in = sr_ge ? SD_W'(sr_sum - {1'b0, win_dh_ff}) : SD_W'(sr_sum);
      srow_in     = srow_ff + kqy_ff + SD_W'(sr_ge);

      sc_sum      = {1'b0, scol_rem_ff} + {1'b0, krx_ff};
      sc_ge       = sc_sum >= {1'b0, win_dw_ff};
      scol_rem_in = sc_ge ? SD_W'(sc_sum - {1'b0, win_dw_ff}) : SD_W'(sc_sum);
      scol_in     = scol_ff + kqx_ff + SD_W'(sc_ge);

      rd_addr = ssb_pkg::ADDR_W'(AD_W'(srow_ff) * AD_W'(win_sw_ff) + AD_W'(scol_ff));
   end

   always_ff @(posedge clock) begin
      win_sw_ff  <= sw_c;
      win_sh_ff  <= sh_c;
      win_dw_ff  <= dw_c;
      win_dh_ff  <= dh_c;
      win_x0_ff  <= x0_w[SD_W-1:0];
      win_y0_ff  <= y0_w[SD_W-1:0];
      win_x1_ff  <= x1_w[SD_W-1:0];
      win_y1_ff  <= y1_w[SD_W-1:0];
      win_vis_ff <= vis_in;
   end

   // Sprite store.
   always_ff @(posedge clock) begin
      if (req_accept && (req_cmd == ssb_pkg::CMD_LOAD)) begin
         store_mem[req_load_index] <= req_load_pixel;
      end
      if (do_walk) begin
         rdata_ff <= store_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff             <= S_IDLE;
         in_run_ff            <= 1'b0;
         rsp_valid_ff         <= 1'b0;
         cfg_src_width_ff     <= ssb_pkg::RST_SRC_WIDTH;
         cfg_src_height_ff    <= ssb_pkg::RST_SRC_HEIGHT;
         cfg_scale_ff         <= ssb_pkg::RST_SCALE;
         cfg_pos_x_ff         <= ssb_pkg::RST_POS_X;
         cfg_pos_y_ff         <= ssb_pkg::RST_POS_Y;
         cfg_key_ff           <= ssb_pkg::RST_KEY;
         cfg_screen_width_ff  <= ssb_pkg::RST_SCREEN_WIDTH;
         cfg_screen_height_ff <= ssb_pkg::RST_SCREEN_HEIGHT;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_accept && (req_cmd == ssb_pkg::CMD_STEP)) begin
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               if (!win_vis_ff) begin
                  in_run_ff <= 1'b0;
                  empty_ff  <= 1'b1;
                  state_ff  <= S_OUT;
               end else if (!in_run_ff) begin
                  col_ff     <= win_x0_ff;
                  row_ff     <= win_y0_ff;
                  div_op_ff  <= OP_COL_STEP;
                  div_cnt_ff <= '0;
                  div_rem_ff <= '0;
                  div_quo_ff <= ld_num_in;
                  div_den_ff <= ld_den_in;
                  state_ff   <= S_DIV;
               end else begin
                  state_ff <= S_OUT;
               end
            end
            S_DIV: begin
               div_rem_ff <= div_rem_in[SD_W-1:0];
               div_quo_ff <= div_quo_in;
               div_cnt_ff <= div_cnt_ff + 1'b1;
               if (div_cnt_ff == DIV_LAST) begin
                  unique case (div_op_ff)
                     OP_COL_STEP: begin
                        kqx_ff <= div_quo_in[SD_W-1:0];
                        krx_ff <= div_rem_in[SD_W-1:0];
                     end
                     OP_COL_START: begin
                        scol_ff     <= div_quo_in[SD_W-1:0];
                        scol_rem_ff <= div_rem_in[SD_W-1:0];
                     end
                     OP_ROW_STEP: begin
                        kqy_ff <= div_quo_in[SD_W-1:0];
                        kry_ff <= div_rem_in[SD_W-1:0];
                     end
                     OP_ROW_START: begin
                        srow_ff      <= div_quo_in[SD_W-1:0];
                        srow_rem_ff  <= div_rem_in[SD_W-1:0];
                        srow0_ff     <= div_quo_in[SD_W-1:0];
                        srow0_rem_ff <= div_rem_in[SD_W-1:0];
                     end
                  endcase
                  if (div_op_ff == OP_ROW_START) begin
                     in_run_ff <= 1'b1;
                     state_ff  <= S_READ;
                  end else begin
                     div_op_ff  <= ld_op;
                     div_cnt_ff <= '0;
                     div_rem_ff <= '0;
                     div_quo_ff <= ld_num_in;
                     div_den_ff <= ld_den_in;
                  end
               end
            end
            S_READ: begin
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  if (empty_ff) begin
                     rsp_we_ff    <= 1'b0;
                     rsp_x_ff     <= '0;
                     rsp_y_ff     <= '0;
                     rsp_pixel_ff <= '0;
                     rsp_last_ff  <= 1'b1;
                     rsp_none_ff  <= 1'b1;
                  end else begin
                     rsp_we_ff    <= (rdata_ff != cfg_key_ff);
                     rsp_x_ff     <= out_x_ff;
                     rsp_y_ff     <= out_y_ff;
                     rsp_pixel_ff <= rdata_ff;
                     rsp_last_ff  <= out_last_ff;
                     rsp_none_ff  <= 1'b0;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase

         if (do_walk) begin
            empty_ff    <= 1'b0;
            out_x_ff    <= ssb_pkg::COORD_W'(cfg_pos_x_ff) + ssb_pkg::COORD_W'(col_ff);
            out_y_ff    <= ssb_pkg::COORD_W'(cfg_pos_y_ff) + ssb_pkg::COORD_W'(row_ff);
            out_last_ff <= row_wrap && col_done;
            if (!row_wrap) begin
               row_ff      <= row_nx[SD_W-1:0];
               srow_ff     <= srow_in;
               srow_rem_ff <= srow_rem_in;
            end else begin
               row_ff      <= win_y0_ff;
               srow_ff     <= srow0_ff;
               srow_rem_ff <= srow0_rem_ff;
               col_ff      <= col_nx[SD_W-1:0];
               scol_ff     <= scol_in;
               scol_rem_ff <= scol_rem_in;
               if (col_done) begin
                  in_run_ff <= 1'b0;
               end
            end
         end

         // Any register write cancels a draw in progress.
         if (csr_write) begin
            in_run_ff <= 1'b0;
            unique case (csr_index)
               ssb_pkg::REG_SRC_WIDTH: begin
                  cfg_src_width_ff <= csr_data[ssb_pkg::DIM_W-1:0];
               end
               ssb_pkg::REG_SRC_HEIGHT: begin
                  cfg_src_height_ff <= csr_data[ssb_pkg::DIM_W-1:0];
               end
               ssb_pkg::REG_SCALE: begin
                  cfg_scale_ff <= csr_data[ssb_pkg::SCALE_W-1:0];
               end
               ssb_pkg::REG_POS_X: begin
                  cfg_pos_x_ff <= csr_data[ssb_pkg::POS_W-1:0];
               end
               ssb_pkg::REG_POS_Y: begin
                  cfg_pos_y_ff <= csr_data[ssb_pkg::POS_W-1:0];
               end
               ssb_pkg::REG_KEY: begin
                  cfg_key_ff <= csr_data[ssb_pkg::KEY_W-1:0];
               end
               ssb_pkg::REG_SCREEN_WIDTH: begin
                  cfg_screen_width_ff <= csr_data[ssb_pkg::SCR_W-1:0];
               end
               ssb_pkg::REG_SCREEN_HEIGHT: begin
                  cfg_screen_height_ff <= csr_data[ssb_pkg::SCR_W-1:0];
               end
            endcase
         end
      end
   end

endmodule

`default_nettype wire
